[hw/rtl/tscf_pkg.sv]
package tscf_pkg;

	localparam int DEF_VALUE_BITS = 16;
	localparam int DEF_TIME_BITS  = 32;

	localparam int FIELD_BITS = 16;
	localparam int MS_BITS    = 32;
	localparam int P_FRAC     = 16;
	localparam int P_BITS     = P_FRAC + 1;
	localparam int DIV_STEPS  = P_FRAC;
	localparam int CNT_BITS   = $clog2(DIV_STEPS + 1);

	localparam logic [P_BITS-1:0] P_ONE   = P_BITS'(1) << P_FRAC;
	localparam logic [P_BITS-1:0] P_ZERO  = '0;
	localparam int                P_ROUND = 1 << (P_FRAC - 1);

	localparam logic [1:0] OP_SNAP = 2'd0;
	localparam logic [1:0] OP_RAMP = 2'd1;
	localparam logic [1:0] OP_ADV  = 2'd2;

	localparam logic [1:0] CH_LEVEL = 2'd0;
	localparam logic [1:0] CH_ANGLE = 2'd1;
	localparam logic [1:0] CH_MAG   = 2'd2;

	localparam int PC_BITS = 4;
	localparam logic [PC_BITS-1:0] PC_WAIT = 4'd0;
	localparam logic [PC_BITS-1:0] PC_ADVT = 4'd3;
	localparam logic [PC_BITS-1:0] PC_DIVS = 4'd5;
	localparam logic [PC_BITS-1:0] PC_LOAD = 4'd14;
	localparam logic [PC_BITS-1:0] PC_EMIT = 4'd15;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_ACCEPT,
		ACT_LOAD,
		ACT_ADVT,
		ACT_DIVI,
		ACT_DIVS,
		ACT_PSET,
		ACT_MUL,
		ACT_ACC,
		ACT_EMIT
	} act_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_NO_IN,
		COND_IS_LOAD,
		COND_NOT_ADV,
		COND_DIV_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		act_t               act;
		cond_t              cond;
		logic [PC_BITS-1:0] target;
		logic [1:0]         ch;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic is_load;
		logic not_adv;
		logic div_more;
		logic out_busy;
	} status_t;

	function automatic ctrl_t cw(act_t a, cond_t c, logic [PC_BITS-1:0] t, logic [1:0] ch);
		ctrl_t w;
		w.act    = a;
		w.cond   = c;
		w.target = t;
		w.ch     = ch;
		return w;
	endfunction

	function automatic ctrl_t rom_word(logic [PC_BITS-1:0] pc);
		ctrl_t w;
		unique case (pc)
			4'd0:    w = cw(ACT_ACCEPT, COND_NO_IN,    PC_WAIT, CH_LEVEL);
			4'd1:    w = cw(ACT_NONE,   COND_IS_LOAD,  PC_LOAD, CH_LEVEL);
			4'd2:    w = cw(ACT_NONE,   COND_NOT_ADV,  PC_EMIT, CH_LEVEL);
			4'd3:    w = cw(ACT_ADVT,   COND_NEXT,     PC_WAIT, CH_LEVEL);
			4'd4:    w = cw(ACT_DIVI,   COND_NEXT,     PC_WAIT, CH_LEVEL);
			4'd5:    w = cw(ACT_DIVS,   COND_DIV_MORE, PC_DIVS, CH_LEVEL);
			4'd6:    w = cw(ACT_PSET,   COND_NEXT,     PC_WAIT, CH_LEVEL);
			4'd7:    w = cw(ACT_MUL,    COND_NEXT,     PC_WAIT, CH_LEVEL);
			4'd8:    w = cw(ACT_ACC,    COND_NEXT,     PC_WAIT, CH_LEVEL);
			4'd9:    w = cw(ACT_MUL,    COND_NEXT,     PC_WAIT, CH_ANGLE);
			4'd10:   w = cw(ACT_ACC,    COND_NEXT,     PC_WAIT, CH_ANGLE);
			4'd11:   w = cw(ACT_MUL,    COND_NEXT,     PC_WAIT, CH_MAG);
			4'd12:   w = cw(ACT_ACC,    COND_ALWAYS,   PC_EMIT, CH_MAG);
			4'd14:   w = cw(ACT_LOAD,   COND_NEXT,     PC_WAIT, CH_LEVEL);
			4'd15:   w = cw(ACT_EMIT,   COND_OUT_BUSY, PC_EMIT, CH_LEVEL);
			default: w = cw(ACT_NONE,   COND_ALWAYS,   PC_EMIT, CH_LEVEL);
		endcase
		return w;
	endfunction

endpackage

[hw/rtl/tscf_seq.sv]
module tscf_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  tscf_pkg::status_t status,
	output tscf_pkg::ctrl_t   ctrl
);

	logic [tscf_pkg::PC_BITS-1:0] pc_q;
	logic [tscf_pkg::PC_BITS-1:0] pc_next;
	logic                         take;

	assign ctrl = tscf_pkg::rom_word(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			tscf_pkg::COND_NEXT:     take = 1'b0;
			tscf_pkg::COND_ALWAYS:   take = 1'b1;
			tscf_pkg::COND_NO_IN:    take = !status.in_valid;
			tscf_pkg::COND_IS_LOAD:  take = status.is_load;
			tscf_pkg::COND_NOT_ADV:  take = status.not_adv;
			tscf_pkg::COND_DIV_MORE: take = status.div_more;
			tscf_pkg::COND_OUT_BUSY: take = status.out_busy;
			default:                 take = 1'b0;
		endcase
		pc_next = take ? ctrl.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= tscf_pkg::PC_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

[hw/rtl/tscf_div.sv]
module tscf_div #(
	parameter int TIME_BITS = tscf_pkg::DEF_TIME_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        init,
	input  logic                        step,
	input  logic [TIME_BITS-2:0]        num,
	input  logic [TIME_BITS-2:0]        den,
	output logic [tscf_pkg::P_FRAC-1:0] quot,
	output logic                        more
);

	logic [TIME_BITS-1:0]          rem_q;
	logic [tscf_pkg::P_FRAC-1:0]   quot_q;
	logic [tscf_pkg::CNT_BITS-1:0] cnt_q;
	logic [TIME_BITS-1:0]          shifted;
	logic                          fits;

	assign shifted = {rem_q[TIME_BITS-2:0], 1'b0};
	assign fits    = shifted >= {1'b0, den};
	assign quot    = quot_q;
	assign more    = cnt_q != tscf_pkg::CNT_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (init) begin
			cnt_q <= tscf_pkg::CNT_BITS'(tscf_pkg::DIV_STEPS);
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			rem_q  <= {1'b0, num};
			quot_q <= '0;
		end else if (step) begin
			rem_q  <= fits ? shifted - {1'b0, den} : shifted;
			quot_q <= {quot_q[tscf_pkg::P_FRAC-2:0], fits};
		end
	end

endmodule

[hw/rtl/tscf_dp.sv]
module tscf_dp #(
	parameter int VALUE_BITS = tscf_pkg::DEF_VALUE_BITS,
	parameter int TIME_BITS  = tscf_pkg::DEF_TIME_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tscf_pkg::ctrl_t                 ctrl,
	input  logic                            in_valid,
	input  logic [1:0]                      in_op,
	input  logic [tscf_pkg::FIELD_BITS-1:0] in_level,
	input  logic [tscf_pkg::FIELD_BITS-1:0] in_angle,
	input  logic [tscf_pkg::FIELD_BITS-1:0] in_mag,
	input  logic signed [tscf_pkg::MS_BITS-1:0] in_dur,
	input  logic signed [tscf_pkg::MS_BITS-1:0] in_step,
	input  logic                            out_ready,
	output tscf_pkg::status_t               status,
	output logic                            out_valid,
	output logic [tscf_pkg::FIELD_BITS-1:0] out_level,
	output logic [tscf_pkg::FIELD_BITS-1:0] out_angle,
	output logic [tscf_pkg::FIELD_BITS-1:0] out_mag,
	output logic                            out_active,
	output logic [tscf_pkg::P_BITS-1:0]     out_progress
);

	localparam int VB = VALUE_BITS;
	localparam int TB = TIME_BITS;
	localparam int DW = VB + 2;
	localparam int PW = DW + tscf_pkg::P_BITS + 1;
	localparam logic signed [DW-1:0] HALF = DW'(1) <<< (VB - 1);
	localparam logic signed [DW-1:0] FULL = DW'(1) <<< VB;

	logic [VB-1:0] org_q [3];
	logic [VB-1:0] tgt_q [3];
	logic [VB-1:0] cur_q [3];
	logic [VB-1:0] nv_q  [3];
	logic [TB-2:0] el_q;
	logic [TB-2:0] dur_q;
	logic [TB-2:0] tdur_q;
	logic [TB-2:0] tstep_q;
	logic [tscf_pkg::P_BITS-1:0] p_q;
	logic [1:0]    op_q;
	logic signed [PW-1:0] prod_q;
	logic          out_valid_q;

	logic [63:0]   lvl_w, ang_w, mag_w;
	logic [63:0]   dur_w, step_w;
	logic [TB-1:0] dur_t, step_t;
	logic [TB-2:0] dur_op, step_op;
	logic          active;
	logic          busy;
	logic          emit;
	logic          snap_now;
	logic [TB-1:0] el_sum;
	logic [VB-1:0] from_v, to_v;
	logic signed [DW-1:0] diff, arc;
	logic signed [PW-1:0] rnd;
	logic [tscf_pkg::P_FRAC-1:0] quot;
	logic          div_more;
	logic [63:0]   c0_w, c1_w, c2_w;

	assign lvl_w  = 64'(in_level);
	assign ang_w  = 64'(in_angle);
	assign mag_w  = 64'(in_mag);
	assign dur_w  = 64'(in_dur);
	assign step_w = 64'(in_step);
	assign dur_t  = dur_w[TB-1:0];
	assign step_t = step_w[TB-1:0];
	assign dur_op  = dur_t[TB-1]  ? '0 : dur_t[TB-2:0];
	assign step_op = step_t[TB-1] ? '0 : step_t[TB-2:0];

	assign active   = (dur_q != '0) && (el_q < dur_q);
	assign busy     = out_valid_q && !out_ready;
	assign emit     = (ctrl.act == tscf_pkg::ACT_EMIT) && !busy;
	assign snap_now = (op_q == tscf_pkg::OP_SNAP) || (tdur_q == '0);
	assign el_sum   = {1'b0, el_q} + {1'b0, tstep_q};

	assign status.in_valid = in_valid;
	assign status.is_load  = (op_q == tscf_pkg::OP_SNAP) || (op_q == tscf_pkg::OP_RAMP);
	assign status.not_adv  = !((op_q == tscf_pkg::OP_ADV) && active);
	assign status.div_more = div_more;
	assign status.out_busy = busy;

	// shortest arc for the angle, plain difference otherwise
	assign from_v = org_q[ctrl.ch];
	assign to_v   = tgt_q[ctrl.ch];
	assign diff   = $signed({2'b00, to_v}) - $signed({2'b00, from_v});
	always_comb begin
		arc = diff;
		if (ctrl.ch == tscf_pkg::CH_ANGLE) begin
			if (diff > HALF) begin
				arc = diff - FULL;
			end else if (diff < -HALF) begin
				arc = diff + FULL;
			end
		end
	end

	assign rnd = prod_q + PW'(tscf_pkg::P_ROUND);

	tscf_div #(
		.TIME_BITS(TB)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.init  (ctrl.act == tscf_pkg::ACT_DIVI),
		.step  (ctrl.act == tscf_pkg::ACT_DIVS),
		.num   (el_q),
		.den   (dur_q),
		.quot  (quot),
		.more  (div_more)
	);

	// input word latch and multiplier product register
	always_ff @(posedge clk) begin
		if ((ctrl.act == tscf_pkg::ACT_ACCEPT) && in_valid) begin
			op_q     <= in_op;
			nv_q[0]  <= lvl_w[VB-1:0];
			nv_q[1]  <= ang_w[VB-1:0];
			nv_q[2]  <= mag_w[VB-1:0];
			tdur_q   <= dur_op;
			tstep_q  <= step_op;
		end
		if (ctrl.act == tscf_pkg::ACT_MUL) begin
			prod_q <= arc * $signed({1'b0, p_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				tgt_q[i] <= '0;
				cur_q[i] <= '0;
			end
			el_q  <= '0;
			dur_q <= '0;
			p_q   <= tscf_pkg::P_ONE;
		end else begin
			unique case (ctrl.act)
				tscf_pkg::ACT_LOAD: begin
					el_q <= '0;
					if (snap_now) begin
						for (int i = 0; i < 3; i++) begin
							org_q[i] <= nv_q[i];
							tgt_q[i] <= nv_q[i];
							cur_q[i] <= nv_q[i];
						end
						dur_q <= '0;
						p_q   <= tscf_pkg::P_ONE;
					end else begin
						for (int i = 0; i < 3; i++) begin
							org_q[i] <= cur_q[i];
							tgt_q[i] <= nv_q[i];
						end
						dur_q <= tdur_q;
						p_q   <= tscf_pkg::P_ZERO;
					end
				end
				tscf_pkg::ACT_ADVT: begin
					el_q <= (el_sum > {1'b0, dur_q}) ? dur_q : el_sum[TB-2:0];
				end
				tscf_pkg::ACT_PSET: begin
					p_q <= (el_q == dur_q) ? tscf_pkg::P_ONE : {1'b0, quot};
				end
				tscf_pkg::ACT_ACC: begin
					cur_q[ctrl.ch] <= from_v + rnd[VB+tscf_pkg::P_FRAC-1:tscf_pkg::P_FRAC];
				end
				default: begin
				end
			endcase
		end
	end

	assign c0_w = 64'(cur_q[0]);
	assign c1_w = 64'(cur_q[1]);
	assign c2_w = 64'(cur_q[2]);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_level    <= c0_w[tscf_pkg::FIELD_BITS-1:0];
			out_angle    <= c1_w[tscf_pkg::FIELD_BITS-1:0];
			out_mag      <= c2_w[tscf_pkg::FIELD_BITS-1:0];
			out_active   <= active;
			out_progress <= p_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/timed_state_crossfade.sv]
// flow: a word is accepted in the wait state and no new word is taken until its
// result is emitted; snap and ramp start load the new values, idle advance and
// unused operation go straight to emit, and an advance during a ramp runs time
// advance, the 16-step progress division and the one shared multiplier used per channel
// reset: arst_n clears all values and both time counters, progress reads complete
module timed_state_crossfade #(
	parameter int VALUE_BITS = tscf_pkg::DEF_VALUE_BITS,
	parameter int TIME_BITS  = tscf_pkg::DEF_TIME_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// new_level, new_angle, new_magnitude, ramp_duration_ms, step_ms
	input  logic [111:0] s_axis_tdata,
	// operation
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// level_out, angle_out, magnitude_out, ramp_active, ramp_progress, zero pad
	output logic [71:0]  m_axis_tdata
);

	tscf_pkg::ctrl_t   ctrl;
	tscf_pkg::status_t status;

	logic [tscf_pkg::FIELD_BITS-1:0] level_out;
	logic [tscf_pkg::FIELD_BITS-1:0] angle_out;
	logic [tscf_pkg::FIELD_BITS-1:0] magnitude_out;
	logic                            ramp_active;
	logic [tscf_pkg::P_BITS-1:0]     ramp_progress;

	assign s_axis_tready = ctrl.act == tscf_pkg::ACT_ACCEPT;

	tscf_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.ctrl  (ctrl)
	);

	tscf_dp #(
		.VALUE_BITS(VALUE_BITS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.in_valid    (s_axis_tvalid),
		.in_op       (s_axis_tuser),
		.in_level    (s_axis_tdata[15:0]),
		.in_angle    (s_axis_tdata[31:16]),
		.in_mag      (s_axis_tdata[47:32]),
		.in_dur      (s_axis_tdata[79:48]),
		.in_step     (s_axis_tdata[111:80]),
		.out_ready   (m_axis_tready),
		.status      (status),
		.out_valid   (m_axis_tvalid),
		.out_level   (level_out),
		.out_angle   (angle_out),
		.out_mag     (magnitude_out),
		.out_active  (ramp_active),
		.out_progress(ramp_progress)
	);

	assign m_axis_tdata = {6'd0, ramp_progress, ramp_active, magnitude_out, angle_out, level_out};

endmodule

[sim/timed_state_crossfade_test.sv]
`timescale 1ns / 100ps

module timed_state_crossfade_test;

	localparam logic [1:0] OP_NONE    = 2'd3;
	localparam int         IDLE_LIMIT = 4000;
	localparam int         TAIL_WORDS = 60;
	localparam int         LONG_AT    = 300;
	localparam int         LONG_HOLD  = 150;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] level;
		logic [15:0] angle;
		logic [15:0] mag;
		logic [31:0] dur;
		logic [31:0] step;
		bit          drain;
	} fade_cmd_t;

	typedef struct packed {
		logic [15:0] level;
		logic [15:0] angle;
		logic [15:0] mag;
		logic        active;
		logic [16:0] prog;
	} fade_state_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// new_level, new_angle, new_magnitude, ramp_duration_ms, step_ms
	logic [111:0] s_axis_tdata = '0;
	// operation
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// level_out, angle_out, magnitude_out, ramp_active, ramp_progress, zero pad
	logic [71:0]  m_axis_tdata;

	timed_state_crossfade u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [15:0] org_v [3];
	logic [15:0] tgt_v [3];
	logic [15:0] cur_v [3];
	logic [30:0] elapsed_ms;
	logic [30:0] length_ms;

	fade_cmd_t   cmd_q [$];
	fade_state_t fade_expect_q [$];
	fade_cmd_t   drv_cmd;

	logic in_fire = 1'b0;
	int   send_gap = 0;
	int   hold_left = 0;
	bit   long_hold_done = 0;
	int   total_cmds = 1 << 30;
	int   words_in = 0;
	int   words_out = 0;
	int   errors = 0;
	int   idle_cycles = 0;
	int   n_snap = 0;
	int   n_ramp = 0;
	int   n_adv = 0;
	int   n_adv_live = 0;
	int   n_none = 0;

	function automatic logic [30:0] clip_ms(logic [31:0] raw);
		return raw[31] ? 31'd0 : raw[30:0];
	endfunction

	function automatic bit ramp_running();
		return length_ms != 0 && elapsed_ms < length_ms;
	endfunction

	function automatic logic [16:0] progress_now();
		longint unsigned num;
		if (length_ms == 0 || elapsed_ms >= length_ms) begin
			return tscf_pkg::P_ONE;
		end
		num = longint'(elapsed_ms) << 16;
		return 17'(num / length_ms);
	endfunction

	function automatic logic [15:0] blend_lin(logic [15:0] from, logic [15:0] to,
			logic [16:0] p);
		longint acc;
		acc = longint'(from) * (65536 - longint'(p)) + longint'(to) * longint'(p) + 32768;
		return acc[31:16];
	endfunction

	function automatic logic [15:0] blend_arc(logic [15:0] from, logic [15:0] to,
			logic [16:0] p);
		longint d;
		longint acc;
		d = longint'(to) - longint'(from);
		if (d > 32768) begin
			d -= 65536;
		end
		if (d < -32768) begin
			d += 65536;
		end
		acc = (longint'(from) <<< 16) + d * longint'(p) + 32768 + (longint'(65536) <<< 16);
		return acc[31:16];
	endfunction

	task automatic settle_at(logic [15:0] lv, logic [15:0] an, logic [15:0] mg);
		cur_v[0] = lv;
		cur_v[1] = an;
		cur_v[2] = mg;
		for (int i = 0; i < 3; i++) begin
			org_v[i] = cur_v[i];
			tgt_v[i] = cur_v[i];
		end
		elapsed_ms = '0;
		length_ms = '0;
	endtask

	task automatic fade_step(input fade_cmd_t c, output fade_state_t r);
		logic [31:0] sum;
		logic [16:0] p;
		case (c.op)
			tscf_pkg::OP_SNAP: begin
				settle_at(c.level, c.angle, c.mag);
			end
			tscf_pkg::OP_RAMP: begin
				for (int i = 0; i < 3; i++) begin
					org_v[i] = cur_v[i];
				end
				tgt_v[0] = c.level;
				tgt_v[1] = c.angle;
				tgt_v[2] = c.mag;
				elapsed_ms = '0;
				length_ms = clip_ms(c.dur);
				if (length_ms == 0) begin
					settle_at(c.level, c.angle, c.mag);
				end
			end
			tscf_pkg::OP_ADV: begin
				if (ramp_running()) begin
					sum = {1'b0, elapsed_ms} + {1'b0, clip_ms(c.step)};
					elapsed_ms = (sum > {1'b0, length_ms}) ? length_ms : sum[30:0];
					p = progress_now();
					cur_v[0] = blend_lin(org_v[0], tgt_v[0], p);
					cur_v[1] = blend_arc(org_v[1], tgt_v[1], p);
					cur_v[2] = blend_lin(org_v[2], tgt_v[2], p);
				end
			end
			default: begin
			end
		endcase
		r.level = cur_v[0];
		r.angle = cur_v[1];
		r.mag = cur_v[2];
		r.active = ramp_running();
		r.prog = progress_now();
	endtask

	task automatic queue_cmd(logic [1:0] op, logic [15:0] lv, logic [15:0] an,
			logic [15:0] mg, logic [31:0] dur, logic [31:0] st);
		fade_cmd_t c;
		c.op = op;
		c.level = lv;
		c.angle = an;
		c.mag = mg;
		c.dur = dur;
		c.step = st;
		c.drain = 0;
		cmd_q.push_back(c);
	endtask

	function automatic logic [15:0] rnd_val();
		int pick;
		pick = $urandom_range(0, 15);
		case (pick)
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000;
			3: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_fire) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_q.size() != 0 &&
						!(cmd_q[0].drain && fade_expect_q.size() != 0)) begin
					drv_cmd = cmd_q.pop_front();
					s_axis_tdata <= {drv_cmd.step, drv_cmd.dur, drv_cmd.mag, drv_cmd.angle,
						drv_cmd.level};
					s_axis_tuser <= drv_cmd.op;
					s_axis_tvalid <= 1'b1;
					if (cmd_q.size() >= TAIL_WORDS && $urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(1, 14);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!long_hold_done && words_in >= LONG_AT) begin
				long_hold_done = 1;
				hold_left = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (words_in + TAIL_WORDS < total_cmds && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 13);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// input capture, prediction and result check
	always @(posedge clk) begin
		fade_cmd_t   c;
		fade_state_t want;
		fade_state_t got;
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			c.op = s_axis_tuser;
			c.level = s_axis_tdata[15:0];
			c.angle = s_axis_tdata[31:16];
			c.mag = s_axis_tdata[47:32];
			c.dur = s_axis_tdata[79:48];
			c.step = s_axis_tdata[111:80];
			c.drain = 0;
			case (c.op)
				tscf_pkg::OP_SNAP: n_snap++;
				tscf_pkg::OP_RAMP: n_ramp++;
				tscf_pkg::OP_ADV: begin
					n_adv++;
					if (ramp_running()) begin
						n_adv_live++;
					end
				end
				default: n_none++;
			endcase
			fade_step(c, want);
			fade_expect_q.push_back(want);
			words_in++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.level = m_axis_tdata[15:0];
			got.angle = m_axis_tdata[31:16];
			got.mag = m_axis_tdata[47:32];
			got.active = m_axis_tdata[48];
			got.prog = m_axis_tdata[65:49];
			if (fade_expect_q.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected output word %h", m_axis_tdata);
				end
			end else begin
				want = fade_expect_q.pop_front();
				if (got !== want || m_axis_tdata[71:66] !== 6'd0) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch on word %0d: expected lvl %h ang %h mag %h act %b prog %h",
							words_out, want.level, want.angle, want.mag, want.active, want.prog);
						$display("                     got lvl %h ang %h mag %h act %b prog %h pad %h",
							got.level, got.angle, got.mag, got.active, got.prog,
							m_axis_tdata[71:66]);
					end
				end
			end
			words_out++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
			idle_cycles++;
		end else begin
			idle_cycles = 0;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int          live;
		int          roll;
		int          n;
		int unsigned span;
		logic [31:0] st;

		settle_at(16'd0, 16'd0, 16'd0);

		// directed
		queue_cmd(tscf_pkg::OP_ADV, 16'h1111, 16'h2222, 16'h3333, 32'd500, 32'd100);
		queue_cmd(OP_NONE, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff);
		queue_cmd(tscf_pkg::OP_SNAP, 16'hffff, 16'hffff, 16'hffff, 32'h7fffffff, 32'h7fffffff);
		queue_cmd(tscf_pkg::OP_SNAP, 16'h0000, 16'h0000, 16'h0000, 32'd0, 32'd0);
		queue_cmd(tscf_pkg::OP_RAMP, 16'hffff, 16'h8000, 16'hffff, 32'd1000, 32'd0);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'd0);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, -32'sd5);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'd250);
		queue_cmd(OP_NONE, 16'h0, 16'h0, 16'h0, 32'd0, 32'd0);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'h7fffffff);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'd10);
		queue_cmd(tscf_pkg::OP_SNAP, 16'h1234, 16'hf000, 16'h0100, 32'd0, 32'd0);
		queue_cmd(tscf_pkg::OP_RAMP, 16'h0000, 16'h1000, 16'hffff, 32'd3, 32'd0);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'd1);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'd1);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'd1);
		queue_cmd(tscf_pkg::OP_RAMP, 16'habcd, 16'h8000, 16'h00ff, 32'd0, 32'd0);
		queue_cmd(tscf_pkg::OP_RAMP, 16'h5a5a, 16'h8000, 16'ha5a5, 32'h80000000, 32'd0);
		queue_cmd(tscf_pkg::OP_RAMP, 16'hffff, 16'h0000, 16'h0000, 32'h7fffffff, 32'd0);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'h7ffffffe);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'd1);
		queue_cmd(tscf_pkg::OP_SNAP, 16'h0000, 16'h1000, 16'h0000, 32'd0, 32'd0);
		queue_cmd(tscf_pkg::OP_RAMP, 16'hffff, 16'h9000, 16'h8000, 32'd7, 32'd0);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'd3);
		queue_cmd(tscf_pkg::OP_ADV, 16'h0, 16'h0, 16'h0, 32'd0, 32'd100);

		// random: mostly ramps followed by a few time steps
		live = 0;
		while (live < 650) begin
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				queue_cmd(tscf_pkg::OP_SNAP, rnd_val(), rnd_val(), rnd_val(), $urandom,
					$urandom);
				live++;
			end else if (roll < 82) begin
				span = (roll < 76) ? $urandom_range(1, 3000) : $urandom_range(1, 32'h7fffffff);
				queue_cmd(tscf_pkg::OP_RAMP, rnd_val(), rnd_val(), rnd_val(), span, $urandom);
				live++;
				n = $urandom_range(1, 6);
				repeat (n) begin
					st = $urandom_range(0, span / 2 + 1);
					if ($urandom_range(0, 9) == 0) begin
						st = $urandom;
					end
					queue_cmd(tscf_pkg::OP_ADV, rnd_val(), rnd_val(), rnd_val(), $urandom, st);
					live++;
				end
			end else begin
				n = $urandom_range(0, 3);
				queue_cmd(2'(n), rnd_val(), rnd_val(), rnd_val(), $urandom, $urandom);
				if (n != OP_NONE) begin
					live++;
				end
			end
		end
		cmd_q[cmd_q.size() / 2].drain = 1;
		total_cmds = cmd_q.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_q.size() != 0 || s_axis_tvalid) begin
			@(negedge clk);
		end
		while (fade_expect_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (40) @(posedge clk);

		$display("covered %0d snaps, %0d ramp starts, %0d time steps (%0d during a ramp), %0d unused ops",
			n_snap, n_ramp, n_adv, n_adv_live, n_none);
		$display("%0d words checked against prediction, %0d mismatches", words_out, errors);
		if (errors == 0 && fade_expect_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
